>>> rtl/wsu_pkg.sv
`default_nettype none

package wsu_pkg;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_EXT_HI = 6'b000100,
    PH_EXT_LO = 6'b001000,
    PH_KEY    = 6'b010000,
    PH_DATA   = 6'b100000
  } phase_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_CLOSE = 2'd2;

  // First header byte: FIN set, RSV clear, then the opcode.
  localparam logic [7:0] FIN_RSV_MASK = 8'd240;
  localparam logic [7:0] FIN_ONLY     = 8'd128;
  localparam logic [3:0] OPC_TEXT     = 4'd1;
  localparam logic [3:0] OPC_CLOSE    = 4'd8;

  // Second header byte: length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Configuration port.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic [15:0] MAX_LEN_RESET = 16'd4088;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/websocket_frame_unmasker.sv
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    data_byte, frame_start
// output    out_valid / out_stall  payload_byte, has_byte, status, last
// config    APB psel/penable       paddr, pwdata, prdata (max_payload_length)
//
// Each input word is captured in the input register; once the result register is
// free or being emptied, the header parser and the unmask XOR update the frame state
// and fill the result register. A new word is accepted in every cycle the words flow.
// Reset (rst, synchronous) returns the parser to waiting for a frame start and
// sets max_payload_length to 4088. When the result register is stalled, the input
// register holds its word and in_stall goes high; words that give no result
// (header bytes, mask key bytes, stray bytes) pass through without a result word.

module websocket_frame_unmasker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         frame_start,
  // Output channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        payload_byte,
  output logic                              has_byte,
  output logic [1:0]                        status,
  output logic                              last,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wsu_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wsu_pkg::PDATA_W-1:0]  pwdata,
  output logic [wsu_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import wsu_pkg::*;

  logic        s1_valid;
  in_word_t    s1_word;
  logic        advance;
  logic        emit;
  result_t     result;
  logic [15:0] max_len;
  logic        reg_wr;

  // The one register sits at byte address 0; the upper address bit selects it.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_MAX_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (reg_wr) begin
      max_len <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == REG_MAX_LEN) begin
      prdata = {{(PDATA_W-16){1'b0}}, max_len};
    end else begin
      prdata = '0;
    end
  end

  // The held word is processed when the result register is free or being emptied.
  assign advance = s1_valid && (!out_valid || !out_stall);

  wsu_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_word     (s1_word)
  );

  wsu_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (s1_word),
    .max_len (max_len),
    .emit    (emit),
    .result  (result)
  );

  wsu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .emit         (emit),
    .result       (result),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .has_byte     (has_byte),
    .status       (status),
    .last         (last)
  );

  // Error and close results never carry a payload byte.
  a_no_byte_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> !has_byte && (payload_byte == 8'h00) && last)
    else $error("fault result carries payload");

  // A result without a byte is always a frame end.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> last)
    else $error("byteless result is not a frame end");

  // The input side stalls only while a word waits in the input register.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked word");

  // Status stays within the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK) || (status == STATUS_ERROR) ||
                  (status == STATUS_CLOSE))
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> rtl/wsu_in_stage.sv
`default_nettype none

module wsu_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  input  wire logic              advance,
  output logic                   s1_valid,
  output wsu_pkg::in_word_t      s1_word
);
  import wsu_pkg::*;

  logic load;

  // The register refills in the same cycle it drains.
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_word.data  <= data_byte;
      s1_word.start <= frame_start;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsu_parse.sv
`default_nettype none

module wsu_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire wsu_pkg::in_word_t word,
  input  wire logic [15:0]       max_len,
  output logic                   emit,
  output wsu_pkg::result_t       result
);
  import wsu_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] total, total_next;
  logic [15:0] count, count_next;
  logic [31:0] key, key_next;
  logic        masked, masked_next;
  logic [1:0]  hdr, hdr_next;

  logic [7:0]  b;
  logic [6:0]  code;
  logic [15:0] ext_total;
  logic [15:0] cnt_inc;
  logic [7:0]  key_byte;
  logic        len_done;
  logic [15:0] len_total;
  logic        len_masked;

  assign b         = word.data;
  assign code      = word.data[6:0];
  assign ext_total = {total[15:8], word.data};
  assign cnt_inc   = count + 16'd1;
  assign key_byte  = key[{count[1:0], 3'b000} +: 8];

  always_comb begin
    phase_next  = phase;
    total_next  = total;
    count_next  = count;
    key_next    = key;
    masked_next = masked;
    hdr_next    = hdr;
    emit        = 1'b0;
    result      = '{payload_byte: 8'h00, has_byte: 1'b0, status: STATUS_OK, last: 1'b0};
    len_done    = 1'b0;
    len_total   = total;
    len_masked  = masked;

    if (word.start) begin
      // A frame start always restarts parsing, whatever was in progress.
      emit        = 1'b1;
      result.last = 1'b1;
      phase_next  = PH_IDLE;
      if ((b & FIN_RSV_MASK) != FIN_ONLY) begin
        result.status = STATUS_ERROR;
      end else if (b[3:0] == OPC_CLOSE) begin
        result.status = STATUS_CLOSE;
      end else if (b[3:0] != OPC_TEXT) begin
        result.status = STATUS_ERROR;
      end else begin
        emit        = 1'b0;
        result.last = 1'b0;
        phase_next  = PH_LEN;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_LEN: begin
          masked_next = b[7];
          if (code == LEN_EXT64) begin
            emit          = 1'b1;
            result.status = STATUS_ERROR;
            result.last   = 1'b1;
            phase_next    = PH_IDLE;
          end else if (code == LEN_EXT16) begin
            phase_next = PH_EXT_HI;
          end else begin
            total_next = {9'd0, code};
            len_done   = 1'b1;
            len_total  = {9'd0, code};
            len_masked = b[7];
          end
        end
        PH_EXT_HI: begin
          total_next = {b, 8'h00};
          phase_next = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          total_next = ext_total;
          if (ext_total > max_len) begin
            emit          = 1'b1;
            result.status = STATUS_ERROR;
            result.last   = 1'b1;
            phase_next    = PH_IDLE;
          end else begin
            len_done  = 1'b1;
            len_total = ext_total;
          end
        end
        PH_KEY: begin
          key_next[{hdr, 3'b000} +: 8] = b;
          hdr_next = hdr + 2'd1;
          if (hdr == 2'd3) begin
            if (total == 16'd0) begin
              emit        = 1'b1;
              result.last = 1'b1;
              phase_next  = PH_IDLE;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          count_next          = cnt_inc;
          emit                = 1'b1;
          result.payload_byte = b ^ key_byte;
          result.has_byte     = 1'b1;
          result.last         = (cnt_inc == total);
          if (cnt_inc == total) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // Length known: start key capture, the payload, or end an empty frame.
      if (len_done) begin
        count_next = 16'd0;
        hdr_next   = 2'd0;
        key_next   = 32'd0;
        if (len_masked) begin
          phase_next = PH_KEY;
        end else if (len_total == 16'd0) begin
          emit        = 1'b1;
          result.last = 1'b1;
          phase_next  = PH_IDLE;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      total  <= 16'd0;
      count  <= 16'd0;
      key    <= 32'd0;
      masked <= 1'b0;
      hdr    <= 2'd0;
    end else if (advance) begin
      phase  <= phase_next;
      total  <= total_next;
      count  <= count_next;
      key    <= key_next;
      masked <= masked_next;
      hdr    <= hdr_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsu_out_stage.sv
`default_nettype none

module wsu_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             emit,
  input  wire wsu_pkg::result_t result,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            payload_byte,
  output logic                  has_byte,
  output logic [1:0]            status,
  output logic                  last
);
  import wsu_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      held <= result;
    end
  end

  assign payload_byte = held.payload_byte;
  assign has_byte     = held.has_byte;
  assign status       = held.status;
  assign last         = held.last;

endmodule

`default_nettype wire
